### hw/rtl/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared types and constants for the triangle face normal pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tfn_pkg;

    localparam int NORM_M_WIDTH = 16;
    localparam int SUM_WIDTH    = 34;
    localparam int RHS_WIDTH    = 2 * NORM_M_WIDTH + 30;
    localparam int PROD_WIDTH   = 64;
    localparam int TS_WIDTH     = 50;
    localparam int NORM_STEPS   = 14;
    localparam int OUT_WIDTH    = 16;

    typedef struct packed {
        logic                    neg;
        logic                    ok1;
        logic [RHS_WIDTH-1:0]    r;
        logic [PROD_WIDTH-1:0]   p;
        logic [TS_WIDTH-1:0]     ts;
        logic [NORM_STEPS-1:0]   d;
    } tfn_comp_t;

    typedef struct packed {
        logic                    degen;
        logic [SUM_WIDTH-1:0]    s;
        tfn_comp_t [2:0]         c;
    } tfn_iter_t;

endpackage

`default_nettype wire

### hw/rtl/triangle_face_normal.sv
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal of one triangle per transaction: edges, cross product,
// block scaling and a bit-per-stage normalization search.
//
//  channel | dir | tdata (low bit up)                  | tuser
//  s_      | in  | a_x a_y a_z b_x b_y b_z c_x c_y c_z | -
//  m_      | out | normal_x normal_y normal_z          | degenerate
//
// One triangle per cycle sustained while m_tready stays high; the path from
// the accepting edge to m_tvalid runs through 7 front stages, the 14-stage
// normalization search and the output register.
// Reset clears all stage valid bits; payload registers are not reset.
// Each stage advances when it is empty or the next one advances, so a
// stalled output holds and earlier bubbles still fill.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module triangle_face_normal #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    input  wire logic [((9*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // normal_x, normal_y, normal_z
    output logic [3*tfn_pkg::OUT_WIDTH-1:0]           m_tdata,
    // degenerate
    output logic [0:0]                                m_tuser
);
    import tfn_pkg::*;

    localparam int EW   = COORD_WIDTH + 1;
    localparam int PW   = 2 * COORD_WIDTH + 2;
    localparam int XW   = 2 * COORD_WIDTH + 3;
    localparam int MAGW = 2 * COORD_WIDTH + 1;
    localparam int LENW = $clog2(MAGW + 1);
    localparam int NST  = 8 + NORM_STEPS;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] en;

    always_comb begin
        en[NST-1] = !vld_reg[NST-1] || m_tready;
        for (int i = NST - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NST; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign s_tready = en[0];

    // stage 0: edges
    logic signed [COORD_WIDTH-1:0] crd [9];
    logic signed [EW-1:0] u_reg [3];
    logic signed [EW-1:0] v_reg [3];

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            crd[k] = $signed(s_tdata[k*COORD_WIDTH +: COORD_WIDTH]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int k = 0; k < 3; k++) begin
                u_reg[k] <= EW'(crd[3+k]) - EW'(crd[k]);
                v_reg[k] <= EW'(crd[6+k]) - EW'(crd[3+k]);
            end
        end
    end

    // stage 1: products
    logic signed [PW-1:0] pa_reg [3];
    logic signed [PW-1:0] pb_reg [3];

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            pa_reg[0] <= PW'(u_reg[1]) * PW'(v_reg[2]);
            pb_reg[0] <= PW'(u_reg[2]) * PW'(v_reg[1]);
            pa_reg[1] <= PW'(u_reg[2]) * PW'(v_reg[0]);
            pb_reg[1] <= PW'(u_reg[0]) * PW'(v_reg[2]);
            pa_reg[2] <= PW'(u_reg[0]) * PW'(v_reg[1]);
            pb_reg[2] <= PW'(u_reg[1]) * PW'(v_reg[0]);
        end
    end

    // stage 2: cross product as sign and magnitude
    logic            neg2_reg [3];
    logic [MAGW-1:0] mag2_reg [3];

    always_ff @(posedge aclk) begin
        logic signed [XW-1:0] diff;
        if (en[2]) begin
            for (int k = 0; k < 3; k++) begin
                diff = XW'(pa_reg[k]) - XW'(pb_reg[k]);
                neg2_reg[k] <= diff[XW-1];
                mag2_reg[k] <= diff[XW-1] ? MAGW'(-diff) : MAGW'(diff);
            end
        end
    end

    // stage 3: block scale amount
    logic            neg3_reg [3];
    logic [MAGW-1:0] mag3_reg [3];
    logic [LENW-1:0] sh3_reg;
    logic [MAGW-1:0] mag_or;
    logic [LENW-1:0] blen;

    always_comb begin
        mag_or = mag2_reg[0] | mag2_reg[1] | mag2_reg[2];
        blen = '0;
        for (int i = 0; i < MAGW; i++) begin
            if (mag_or[i]) begin
                blen = LENW'(i + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            neg3_reg <= neg2_reg;
            mag3_reg <= mag2_reg;
            sh3_reg  <= (blen > LENW'(NORM_M_WIDTH)) ? blen - LENW'(NORM_M_WIDTH) : '0;
        end
    end

    // stage 4: scaled magnitudes
    logic                    neg4_reg [3];
    logic [NORM_M_WIDTH-1:0] m4_reg [3];

    always_ff @(posedge aclk) begin
        logic [MAGW-1:0] shifted;
        if (en[4]) begin
            neg4_reg <= neg3_reg;
            for (int k = 0; k < 3; k++) begin
                shifted = mag3_reg[k] >> sh3_reg;
                m4_reg[k] <= shifted[NORM_M_WIDTH-1:0];
            end
        end
    end

    // stage 5: squares
    logic                      neg5_reg [3];
    logic [2*NORM_M_WIDTH-1:0] sq5_reg [3];

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            neg5_reg <= neg4_reg;
            for (int k = 0; k < 3; k++) begin
                sq5_reg[k] <= (2*NORM_M_WIDTH)'(m4_reg[k]) * (2*NORM_M_WIDTH)'(m4_reg[k]);
            end
        end
    end

    // stage 6: sum of squares and search seed
    tfn_iter_t itr [NORM_STEPS+1];
    tfn_iter_t seed;

    always_comb begin
        seed.s = SUM_WIDTH'(sq5_reg[0]) + SUM_WIDTH'(sq5_reg[1]) + SUM_WIDTH'(sq5_reg[2]);
        seed.degen = (seed.s == '0);
        for (int k = 0; k < 3; k++) begin
            seed.c[k].neg = neg5_reg[k];
            seed.c[k].r   = {sq5_reg[k], 30'b0};
            seed.c[k].ok1 = {{(RHS_WIDTH-SUM_WIDTH){1'b0}}, seed.s} <= seed.c[k].r;
            seed.c[k].p   = {{(PROD_WIDTH-SUM_WIDTH){1'b0}}, seed.s};
            seed.c[k].ts  = {{(TS_WIDTH-SUM_WIDTH){1'b0}}, seed.s};
            seed.c[k].d   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            itr[0] <= seed;
        end
    end

    // stages 7..20: one magnitude bit per stage
    for (genvar g = 0; g < NORM_STEPS; g++) begin : g_step
        tfn_norm_step #(
            .K (NORM_STEPS - 1 - g)
        ) u_step (
            .aclk     (aclk),
            .en       (en[7+g]),
            .iter_in  (itr[g]),
            .iter_out (itr[g+1])
        );
    end

    // output stage
    logic [3*OUT_WIDTH-1:0] out_data_reg;
    logic                   out_degen_reg;

    always_ff @(posedge aclk) begin
        logic [OUT_WIDTH-1:0] q;
        if (en[NST-1]) begin
            out_degen_reg <= itr[NORM_STEPS].degen;
            for (int k = 0; k < 3; k++) begin
                if (itr[NORM_STEPS].degen || !itr[NORM_STEPS].c[k].ok1) begin
                    q = '0;
                end else begin
                    q = OUT_WIDTH'(itr[NORM_STEPS].c[k].d) + OUT_WIDTH'(1);
                end
                out_data_reg[k*OUT_WIDTH +: OUT_WIDTH] <=
                    itr[NORM_STEPS].c[k].neg ? -q : q;
            end
        end
    end

    assign m_tvalid   = vld_reg[NST-1];
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_degen_reg;

endmodule

`default_nettype wire

### hw/rtl/tfn_norm_step.sv
// ----------------------------------------------------------------------------
// tfn_norm_step
// One registered step of the normalization search: settles one bit of the
// unit magnitude for all three components.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfn_norm_step #(
    parameter int K = 0
) (
    input  wire logic              aclk,
    input  wire logic              en,
    input  var  tfn_pkg::tfn_iter_t iter_in,
    output var  tfn_pkg::tfn_iter_t iter_out
);
    import tfn_pkg::*;

    tfn_iter_t iter_next;
    tfn_iter_t iter_reg;

    always_comb begin
        logic [PROD_WIDTH+1:0] trial_p;
        iter_next = iter_in;
        for (int k = 0; k < 3; k++) begin
            trial_p = {2'b00, iter_in.c[k].p}
                    + ({{(PROD_WIDTH+2-TS_WIDTH){1'b0}}, iter_in.c[k].ts} << (K + 2))
                    + ({{(PROD_WIDTH+2-SUM_WIDTH){1'b0}}, iter_in.s} << (2 * K + 2));
            if (trial_p <= {{(PROD_WIDTH+2-RHS_WIDTH){1'b0}}, iter_in.c[k].r}) begin
                iter_next.c[k].p    = trial_p[PROD_WIDTH-1:0];
                iter_next.c[k].ts   = iter_in.c[k].ts
                    + ({{(TS_WIDTH-SUM_WIDTH){1'b0}}, iter_in.s} << (K + 1));
                iter_next.c[k].d[K] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            iter_reg <= iter_next;
        end
    end

    assign iter_out = iter_reg;

endmodule

`default_nettype wire

### hw/rtl/tfn_checker.sv
// ----------------------------------------------------------------------------
// tfn_checker
// Port-level checks on the result channel of the face normal block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfn_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 48'd0)
        else $error("degenerate result with nonzero normal");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
            ($signed(m_tdata[15:0]) <= 16'sd16384) && ($signed(m_tdata[15:0]) >= -16'sd16384)
         && ($signed(m_tdata[31:16]) <= 16'sd16384) && ($signed(m_tdata[31:16]) >= -16'sd16384)
         && ($signed(m_tdata[47:32]) <= 16'sd16384) && ($signed(m_tdata[47:32]) >= -16'sd16384))
        else $error("normal component out of unit range");

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
